FILE: hw/rtl/tcm_pkg.sv
// Shared types and constants of the two-way cache miss model.
`default_nettype none

package tcm_pkg;

    // Address and block geometry.
    localparam int ADDR_W      = 32;
    localparam int BLOCK_BYTES = 16;
    localparam int OFFSET_W    = $clog2(BLOCK_BYTES);
    localparam int BLK_W       = ADDR_W - OFFSET_W;

    // Set store geometry.
    localparam int MAX_SETS = 512;
    localparam int SET_W    = $clog2(MAX_SETS);

    // Miss counter width.
    localparam int MISS_W = 32;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_POLICY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_INDEX_BITS = 1'b1;

    // Register widths and reset values.
    localparam int SIB_W = 4;
    localparam logic [SIB_W-1:0] SIB_RESET = 4'd5;

    // Replacement policy codes.
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Request function codes.
    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // One classified request as it travels from front to back.
    typedef struct packed {
        logic             func;
        logic [BLK_W-1:0] blk;
        logic [SET_W-1:0] set;
    } t_item;

    // One row of the set store: both ways of a set and its age bit.
    typedef struct packed {
        logic             older;
        logic             valid1;
        logic [BLK_W-1:0] tag1;
        logic             valid0;
        logic [BLK_W-1:0] tag0;
    } t_row;

    localparam int ROW_W = $bits(t_row);

endpackage

`default_nettype wire

FILE: hw/rtl/tcm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/tcm_front.sv
// Front stage: accepts requests, derives block number and set, and holds them for the queue.
`default_nettype none

module tcm_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_func,
    input  wire logic [tcm_pkg::ADDR_W-1:0] i_byte_address,
    input  wire logic [tcm_pkg::SIB_W-1:0]  i_set_index_bits,
    input  wire logic                       i_block,
    output logic                            o_push_valid,
    input  wire logic                       i_push_ready,
    output tcm_pkg::t_item                  o_item
);

    logic                  r_valid;
    logic                  n_valid;
    tcm_pkg::t_item        r_item;
    tcm_pkg::t_item        n_item;
    logic                  accept;
    logic [tcm_pkg::BLK_W-1:0] blk;
    logic [tcm_pkg::SET_W-1:0] mask;

    // The stage takes a request when it is empty or is handing its request on,
    // and never while the set store is being cleared.
    assign o_ready = !i_block && (!r_valid || i_push_ready);
    assign accept  = i_valid && o_ready;

    // Block number and set index; the mask keeps the low set_index_bits bits.
    assign blk = i_byte_address[tcm_pkg::ADDR_W-1:tcm_pkg::OFFSET_W];

    always_comb begin
        for (int i = 0; i < tcm_pkg::SET_W; i++) begin
            mask[i] = (i < int'(i_set_index_bits));
        end
    end

    always_comb begin
        n_item = r_item;
        if (accept) begin
            n_item.func = i_func;
            n_item.blk  = blk;
            n_item.set  = blk[tcm_pkg::SET_W-1:0] & mask;
        end
    end

    // Stage occupancy.
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_push_valid = r_valid;
    assign o_item       = r_item;

endmodule

`default_nettype wire

FILE: hw/rtl/tcm_queue.sv
// Short request queue that decouples the front stage from the back end.
`default_nettype none

module tcm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire tcm_pkg::t_item i_item,
    output logic                o_pop_valid,
    input  wire logic           i_pop,
    output tcm_pkg::t_item      o_head
);

    localparam int PTR_W = (tcm_pkg::QUEUE_DEPTH > 1) ? $clog2(tcm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tcm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tcm_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(tcm_pkg::QUEUE_DEPTH);

    tcm_pkg::t_item   r_entry [tcm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_head       = r_entry[r_rd_ptr];

    // Pointer and count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tcm_back.sv
// Back end: set store lookup and update, clearing pass, miss counter and result register.
`default_nettype none

module tcm_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_replace_policy,
    input  wire logic           i_pop_valid,
    output logic                o_pop,
    input  wire tcm_pkg::t_item i_head,
    output logic                o_clearing,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_hit,
    output logic                o_way_used,
    output logic [tcm_pkg::MISS_W-1:0] o_miss_total
);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } t_state;

    localparam logic [tcm_pkg::SET_W-1:0]  LAST_SET = tcm_pkg::SET_W'(tcm_pkg::MAX_SETS - 1);
    localparam logic [tcm_pkg::MISS_W-1:0] MISS_MAX = '1;

    t_state                     r_state;
    t_state                     n_state;
    logic [tcm_pkg::SET_W-1:0]  r_clr_idx;
    logic [tcm_pkg::SET_W-1:0]  n_clr_idx;
    tcm_pkg::t_item             r_cur;
    tcm_pkg::t_item             n_cur;
    logic [tcm_pkg::MISS_W-1:0] r_miss;
    logic [tcm_pkg::MISS_W-1:0] n_miss;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic                       r_out_hit;
    logic                       n_out_hit;
    logic                       r_out_way;
    logic                       n_out_way;
    logic [tcm_pkg::MISS_W-1:0] r_out_miss;
    logic [tcm_pkg::MISS_W-1:0] n_out_miss;

    logic                       slot_free;
    logic                       we;
    logic [tcm_pkg::SET_W-1:0]  waddr;
    tcm_pkg::t_row              wrow;
    logic [tcm_pkg::ROW_W-1:0]  rdata;
    tcm_pkg::t_row              row;
    tcm_pkg::t_row              upd_row;
    logic                       hit0;
    logic                       hit1;
    logic                       hit;
    logic                       way;

    // Set store: one row per set, read in the cycle before the update.
    tcm_ram #(
        .WIDTH (tcm_pkg::ROW_W),
        .DEPTH (tcm_pkg::MAX_SETS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wrow),
        .i_raddr (i_head.set),
        .o_rdata (rdata)
    );

    assign row = tcm_pkg::t_row'(rdata);

    // Tag compare on both ways, then victim choice on a miss.
    always_comb begin
        hit0 = row.valid0 && (row.tag0 == r_cur.blk);
        hit1 = row.valid1 && (row.tag1 == r_cur.blk);
        hit  = hit0 || hit1;
        priority if (hit0) begin
            way = 1'b0;
        end else if (hit1) begin
            way = 1'b1;
        end else if (!row.valid0) begin
            way = 1'b0;
        end else if (!row.valid1) begin
            way = 1'b1;
        end else begin
            way = row.older;
        end
    end

    // Row after this access: fill the chosen way on a miss, refresh age on an LRU hit.
    always_comb begin
        upd_row = row;
        if (hit) begin
            if (i_replace_policy == tcm_pkg::POLICY_LRU) begin
                upd_row.older = ~way;
            end
        end else begin
            if (way) begin
                upd_row.tag1   = r_cur.blk;
                upd_row.valid1 = 1'b1;
            end else begin
                upd_row.tag0   = r_cur.blk;
                upd_row.valid0 = 1'b1;
            end
            upd_row.older = ~way;
        end
    end

    // The result register may be refilled once its result is taken.
    assign slot_free = !r_out_valid || i_ready;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_cur       = r_cur;
        n_miss      = r_miss;
        n_out_valid = r_out_valid && !i_ready;
        n_out_hit   = r_out_hit;
        n_out_way   = r_out_way;
        n_out_miss  = r_out_miss;
        o_pop       = 1'b0;
        we          = 1'b0;
        waddr       = r_clr_idx;
        wrow        = '0;
        unique case (r_state)
            ST_CLEAR: begin
                // Zero one row per cycle: valid marks and age bit cleared.
                we        = 1'b1;
                waddr     = r_clr_idx;
                wrow      = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_SET) begin
                    n_clr_idx = '0;
                    n_state   = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_pop_valid && slot_free) begin
                    o_pop = 1'b1;
                    if (i_head.func == tcm_pkg::FUNC_FLUSH) begin
                        // Flush answers at once, then clears the whole store.
                        n_miss      = '0;
                        n_out_valid = 1'b1;
                        n_out_hit   = 1'b0;
                        n_out_way   = 1'b0;
                        n_out_miss  = '0;
                        n_clr_idx   = '0;
                        n_state     = ST_CLEAR;
                    end else begin
                        n_cur   = i_head;
                        n_state = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                // The row read last cycle is compared, updated and written back.
                we    = 1'b1;
                waddr = r_cur.set;
                wrow  = upd_row;
                if (!hit && (r_miss != MISS_MAX)) begin
                    n_miss = r_miss + 1'b1;
                end
                n_out_valid = 1'b1;
                n_out_hit   = hit;
                n_out_way   = way;
                n_out_miss  = (!hit && (r_miss != MISS_MAX)) ? r_miss + 1'b1 : r_miss;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_miss      <= n_miss;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_out_hit  <= n_out_hit;
        r_out_way  <= n_out_way;
        r_out_miss <= n_out_miss;
    end

    assign o_clearing   = (r_state == ST_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_way_used   = r_out_way;
    assign o_miss_total = r_out_miss;

endmodule

`default_nettype wire

FILE: hw/rtl/two_way_cache_miss_model.sv
// Top level of the two-way set-associative cache tag store with miss counting.
//
//   Channel   Signals                                   Direction
//   request   i_valid/o_ready, i_func, i_byte_address   in
//   result    o_valid/i_ready, o_hit, o_way_used,       out
//             o_miss_total
//   config    i_cfg_valid/o_cfg_ready, i_cfg_index,     in
//             i_cfg_data
//
// An access is registered in the front stage and waits in the queue; the back end then reads
// its set row, then compares, writes back and loads the result before it takes another access.
// A flush loads its result as it is taken, then a clearing pass zeroes one set row per
// cycle; the same pass runs after reset, and no request is taken while it runs.
// The two-entry queue lets the front keep taking requests while the back or result side stalls.
`default_nettype none

module two_way_cache_miss_model (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_func,
    input  wire logic [tcm_pkg::ADDR_W-1:0]     i_byte_address,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_hit,
    output logic                                o_way_used,
    output logic [tcm_pkg::MISS_W-1:0]          o_miss_total,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tcm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [tcm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                       r_replace_policy;
    logic [tcm_pkg::SIB_W-1:0]  r_set_index_bits;
    logic                       clearing;
    logic                       push_valid;
    logic                       push_ready;
    tcm_pkg::t_item             push_item;
    logic                       pop_valid;
    logic                       pop;
    tcm_pkg::t_item             head;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replace_policy <= tcm_pkg::POLICY_FIFO;
            r_set_index_bits <= tcm_pkg::SIB_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tcm_pkg::CFG_REPLACE_POLICY: r_replace_policy <= i_cfg_data[0];
                tcm_pkg::CFG_SET_INDEX_BITS: r_set_index_bits <= i_cfg_data[tcm_pkg::SIB_W-1:0];
                default: ;
            endcase
        end
    end

    // Front stage: request intake and set computation.
    tcm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_byte_address   (i_byte_address),
        .i_set_index_bits (r_set_index_bits),
        .i_block          (clearing),
        .o_push_valid     (push_valid),
        .i_push_ready     (push_ready),
        .o_item           (push_item)
    );

    // Request queue between the two halves.
    tcm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_item       (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_head       (head)
    );

    // Back end: set store and miss counter.
    tcm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_replace_policy (r_replace_policy),
        .i_pop_valid      (pop_valid),
        .o_pop            (pop),
        .i_head           (head),
        .o_clearing       (clearing),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_hit            (o_hit),
        .o_way_used       (o_way_used),
        .o_miss_total     (o_miss_total)
    );

endmodule

`default_nettype wire

FILE: dv/two_way_cache_miss_model_tb.sv
// Self-checking testbench for the two-way set-associative cache tag store with miss counting.
`default_nettype none

module two_way_cache_miss_model_tb;

    import tcm_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 10;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_WAIT  = 8;
    localparam int PRINT_CAP    = 100;

    // One expected lookup result.
    typedef struct packed {
        logic              hit;
        logic              way;
        logic [MISS_W-1:0] miss_total;
    } t_lookup;

    logic i_clk;
    logic rst_n = 1'b0;

    // Request channel drivers.
    logic              req_valid = 1'b0;
    logic              req_func  = FUNC_ACCESS;
    logic [ADDR_W-1:0] req_addr  = '0;
    logic              req_ready;

    // Result channel.
    logic              res_valid;
    logic              res_ready = 1'b1;
    logic              res_hit;
    logic              res_way;
    logic [MISS_W-1:0] res_miss_total;

    // Configuration channel drivers.
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_REPLACE_POLICY;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   cfg_ready;

    // Mirror of the tag store, its configuration and the expected results.
    logic [BLK_W-1:0]  tag_store    [MAX_SETS][2];
    logic [1:0]        way_live     [MAX_SETS];
    logic              older_way_of [MAX_SETS];
    logic [MISS_W-1:0] miss_count_model;
    logic              policy_model;
    logic [SIB_W-1:0]  sib_model;
    t_lookup           expected_lookups[$];

    // Address material for the random traffic.
    logic [18:0]       high_pool [3];
    logic [ADDR_W-1:0] recent_addr [4];

    bit gaps_on = 1'b1;
    int error_count;
    int results_checked;
    int hits_seen;
    int flushes_sent;
    int settings_written;

    two_way_cache_miss_model DUT (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_valid        (req_valid),
        .o_ready        (req_ready),
        .i_func         (req_func),
        .i_byte_address (req_addr),
        .o_valid        (res_valid),
        .i_ready        (res_ready),
        .o_hit          (res_hit),
        .o_way_used     (res_way),
        .o_miss_total   (res_miss_total),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d results still outstanding", expected_lookups.size());
        $display("two_way_cache_miss_model_tb NOT OK");
        $finish;
    end

    // Print one mismatch line (up to a cap) and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("Mismatch on %s at result %0d: got %0h, expected %0h",
                     what, results_checked, got, want);
        end
    endtask

    // State of the mirror after reset.
    task automatic reset_mirror();
        for (int s = 0; s < MAX_SETS; s++) begin
            way_live[s]     = 2'b00;
            older_way_of[s] = 1'b0;
        end
        miss_count_model = '0;
        policy_model     = POLICY_FIFO;
        sib_model        = SIB_RESET;
    endtask

    // Work out the result of one accepted request and update the mirror.
    task automatic predict_lookup(input logic func, input logic [ADDR_W-1:0] addr);
        t_lookup          r;
        logic [BLK_W-1:0] blk;
        logic [SET_W-1:0] set_mask;
        logic [SET_W-1:0] set_idx;
        logic             way;
        logic             hit;
        r = '0;
        if (func == FUNC_FLUSH) begin
            for (int s = 0; s < MAX_SETS; s++) begin
                way_live[s]     = 2'b00;
                older_way_of[s] = 1'b0;
            end
            miss_count_model = '0;
            flushes_sent++;
        end else begin
            blk = addr[ADDR_W-1:OFFSET_W];
            // An index width beyond the store acts as the full index.
            if (sib_model >= SET_W) set_mask = '1;
            else set_mask = SET_W'((1 << sib_model) - 1);
            set_idx = blk[SET_W-1:0] & set_mask;
            hit = 1'b0;
            way = 1'b0;
            if (way_live[set_idx][0] && tag_store[set_idx][0] == blk) begin
                hit = 1'b1;
            end else if (way_live[set_idx][1] && tag_store[set_idx][1] == blk) begin
                hit = 1'b1;
                way = 1'b1;
            end
            if (hit) begin
                if (policy_model == POLICY_LRU) older_way_of[set_idx] = ~way;
            end else begin
                // Fill empty ways in order, then replace the older one.
                if (!way_live[set_idx][0]) way = 1'b0;
                else if (!way_live[set_idx][1]) way = 1'b1;
                else way = older_way_of[set_idx];
                tag_store[set_idx][way] = blk;
                way_live[set_idx][way]  = 1'b1;
                older_way_of[set_idx]   = ~way;
                if (miss_count_model != '1) miss_count_model++;
            end
            r.hit = hit;
            r.way = way;
            r.miss_total = miss_count_model;
        end
        expected_lookups.push_back(r);
    endtask

    // Send one request, with an occasional gap in front of it. Valid is left
    // high so the next request can follow without a bubble.
    task automatic send_request(input logic func, input logic [ADDR_W-1:0] addr);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_func  <= func;
        req_addr  <= addr;
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        predict_lookup(func, addr);
        if (func == FUNC_ACCESS) begin
            recent_addr[3] = recent_addr[2];
            recent_addr[2] = recent_addr[1];
            recent_addr[1] = recent_addr[0];
            recent_addr[0] = addr;
        end
    endtask

    // Hold off new requests until every expected result has come back.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle.
    task automatic configure(input logic policy, input logic [SIB_W-1:0] sib);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_REPLACE_POLICY;
        cfg_data  <= {3'($urandom_range(0, 7)), policy};
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        policy_model = policy;
        cfg_index <= CFG_SET_INDEX_BITS;
        cfg_data  <= sib;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        sib_model = sib;
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // Mostly addresses that collide in a few sets, some repeats, some noise.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 10) a = $urandom();
        else if (r < 40) a = {recent_addr[$urandom_range(0, 3)][31:4],
                              4'($urandom_range(0, 15))};
        else a = {high_pool[$urandom_range(0, 2)], 9'($urandom_range(0, 3)),
                  4'($urandom_range(0, 15))};
        return a;
    endfunction

    // One random phase under a given setting.
    task automatic run_phase(input logic policy, input logic [SIB_W-1:0] sib,
                             input int count);
        configure(policy, sib);
        for (int k = 0; k < 3; k++) high_pool[k] = 19'($urandom());
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 49) == 0) send_request(FUNC_FLUSH, $urandom());
            else send_request(FUNC_ACCESS, pick_address());
        end
    endtask

    // Result checking and random back-pressure on the result side.
    always @(posedge i_clk) begin : result_check
        t_lookup want;
        int      stall_left;
        if (rst_n && res_valid && res_ready) begin
            if (expected_lookups.size() == 0) begin
                report_mismatch("result with no request outstanding", res_miss_total, 0);
            end else begin
                want = expected_lookups.pop_front();
                if (res_hit !== want.hit) report_mismatch("hit", res_hit, want.hit);
                if (res_way !== want.way) report_mismatch("way_used", res_way, want.way);
                if (res_miss_total !== want.miss_total) begin
                    report_mismatch("miss_total", res_miss_total, want.miss_total);
                end
                if (want.hit) hits_seen++;
            end
            results_checked++;
        end
        if (stall_left > 0) begin
            stall_left--;
            res_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Default settings after reset, field extremes, fill of both ways.
    task automatic test_reset_defaults();
        send_request(FUNC_ACCESS, 32'h0000_0000);
        send_request(FUNC_ACCESS, 32'hFFFF_FFFF);
        send_request(FUNC_ACCESS, 32'h0000_000F);
        send_request(FUNC_ACCESS, 32'h0000_0200);
        send_request(FUNC_ACCESS, 32'h0000_0400);
        send_request(FUNC_ACCESS, 32'h0000_0000);
    endtask

    // FIFO hits must not refresh the age bit.
    task automatic test_fifo_replacement();
        configure(POLICY_FIFO, 4'd0);
        send_request(FUNC_FLUSH, 32'h0000_0000);
        send_request(FUNC_ACCESS, 32'h1000_0000);
        send_request(FUNC_ACCESS, 32'h2000_0010);
        send_request(FUNC_ACCESS, 32'h1000_0004);
        send_request(FUNC_ACCESS, 32'h3000_0020);
        send_request(FUNC_ACCESS, 32'h1000_0000);
    endtask

    // LRU hits make the hit way the newer one.
    task automatic test_lru_replacement();
        configure(POLICY_LRU, 4'd0);
        send_request(FUNC_FLUSH, 32'hFFFF_FFFF);
        send_request(FUNC_ACCESS, 32'h1000_0000);
        send_request(FUNC_ACCESS, 32'h2000_0010);
        send_request(FUNC_ACCESS, 32'h1000_0008);
        send_request(FUNC_ACCESS, 32'h3000_0020);
        send_request(FUNC_ACCESS, 32'h2000_0010);
    endtask

    // An index width above the store size acts as the full nine bits.
    task automatic test_oversized_index();
        configure(POLICY_LRU, 4'd15);
        send_request(FUNC_ACCESS, 32'h0000_0000);
        send_request(FUNC_ACCESS, 32'h0000_2000);
        send_request(FUNC_ACCESS, 32'h0000_4000);
        send_request(FUNC_ACCESS, 32'h0000_1000);
    endtask

    // Changing the index width keeps the stored entries.
    task automatic test_index_change();
        configure(POLICY_FIFO, 4'd9);
        send_request(FUNC_ACCESS, 32'h0000_4000);
        send_request(FUNC_ACCESS, 32'h0000_1000);
        configure(POLICY_FIFO, 4'd1);
        send_request(FUNC_ACCESS, 32'h0000_2000);
    endtask

    // A flush empties the store and restarts the miss count.
    task automatic test_flush_clears();
        send_request(FUNC_FLUSH, 32'h5A5A_A5A5);
        send_request(FUNC_ACCESS, 32'h0000_4000);
    endtask

    // Random traffic across several settings, extremes included.
    task automatic test_random_traffic();
        run_phase(POLICY_FIFO, 4'd5, 160);
        run_phase(POLICY_LRU, 4'd0, 160);
        run_phase(POLICY_FIFO, 4'd1, 160);
        run_phase(POLICY_LRU, 4'd9, 160);
        run_phase(POLICY_FIFO, 4'd15, 160);
        run_phase(POLICY_LRU, 4'd3, 160);
        run_phase(POLICY_FIFO, 4'd2, 140);
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_unpaused_traffic();
        wait_for_results();
        gaps_on = 1'b0;
        run_phase(POLICY_LRU, 4'd12, 150);
    endtask

    // Drain, summarize and give the verdict.
    task automatic finish_run();
        wait_for_results();
        $display("Checked %0d lookup results: %0d hits, %0d flushes sent",
                 results_checked, hits_seen, flushes_sent);
        $display("Covered %0d register settings, FIFO and LRU, index widths 0 through 15",
                 settings_written);
        if (error_count == 0) begin
            $display("two_way_cache_miss_model_tb OK");
        end else begin
            $display("two_way_cache_miss_model_tb NOT OK");
        end
        $finish;
    endtask

    // Test sequence.
    initial begin
        error_count      = 0;
        results_checked  = 0;
        hits_seen        = 0;
        flushes_sent     = 0;
        settings_written = 0;
        for (int k = 0; k < 4; k++) recent_addr[k] = '0;
        for (int k = 0; k < 3; k++) high_pool[k] = '0;
        reset_mirror();
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_fifo_replacement();
        test_lru_replacement();
        test_oversized_index();
        test_index_change();
        test_flush_clears();
        test_random_traffic();
        test_unpaused_traffic();
        finish_run();
    end

endmodule

`default_nettype wire
